[hdl/kmc_pkg.sv]
`timescale 1ns / 1ps

package kmc_pkg;

  // sizes of the stores and fields
  localparam int COORD_BITS   = 16;
  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 16;
  localparam int PIDX_W       = $clog2(MAX_POINTS);
  localparam int CIDX_W       = $clog2(MAX_CLUSTERS);
  localparam int KCNT_W       = CIDX_W + 1;
  localparam int NCNT_W       = PIDX_W + 1;
  localparam int SUM_W        = COORD_BITS + PIDX_W;
  localparam int MAG_W        = COORD_BITS;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int DIST_W       = SQ_W + 1;
  localparam int DSTEP_W      = $clog2(SUM_W);

  // configuration register widths and indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT     = 2'd2;

  // beat layout
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int MODE_W     = 2;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_LOAD_POINT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_CENTROID = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN           = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ          = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PFETCH,
    S_DIST,
    S_DWAIT,
    S_ACC,
    S_DXS,
    S_DXW,
    S_DYS,
    S_DYW,
    S_EMIT,
    S_RD
  } state_t;

  // squarer phases
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_X,
    SQ_Y
  } sq_phase_t;

endpackage

[hdl/kmc_dist.sv]
`timescale 1ns / 1ps

module kmc_dist (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [kmc_pkg::COORD_BITS-1:0] px,
  input  logic signed [kmc_pkg::COORD_BITS-1:0] py,
  input  logic signed [kmc_pkg::COORD_BITS-1:0] cx,
  input  logic signed [kmc_pkg::COORD_BITS-1:0] cy,
  output logic                                  done,
  output logic        [kmc_pkg::DIST_W-1:0]     sq_dist
);

  kmc_pkg::sq_phase_t              phase_r, phase_nxt;
  logic [kmc_pkg::MAG_W-1:0]       ax_r;
  logic [kmc_pkg::MAG_W-1:0]       ay_r;
  logic [kmc_pkg::SQ_W-1:0]        sq_r;
  logic [kmc_pkg::DIST_W-1:0]      dist_r;
  logic                            done_r, done_nxt;
  logic signed [kmc_pkg::COORD_BITS:0] dx;
  logic signed [kmc_pkg::COORD_BITS:0] dy;
  logic [kmc_pkg::COORD_BITS:0]    dxa;
  logic [kmc_pkg::COORD_BITS:0]    dya;
  logic [kmc_pkg::MAG_W-1:0]       mul_a;
  logic [kmc_pkg::SQ_W-1:0]        prod;

  // coordinate differences and their magnitudes
  always_comb begin
    dx  = {px[kmc_pkg::COORD_BITS-1], px} - {cx[kmc_pkg::COORD_BITS-1], cx};
    dy  = {py[kmc_pkg::COORD_BITS-1], py} - {cy[kmc_pkg::COORD_BITS-1], cy};
    dxa = dx[kmc_pkg::COORD_BITS] ? -dx : dx;
    dya = dy[kmc_pkg::COORD_BITS] ? -dy : dy;
  end

  // one shared squarer, x first then y
  assign mul_a = (phase_r == kmc_pkg::SQ_X) ? ax_r : ay_r;
  assign prod  = mul_a * mul_a;

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    case (phase_r)
      kmc_pkg::SQ_IDLE: begin
        if (start) phase_nxt = kmc_pkg::SQ_X;
      end
      kmc_pkg::SQ_X: phase_nxt = kmc_pkg::SQ_Y;
      kmc_pkg::SQ_Y: begin
        phase_nxt = kmc_pkg::SQ_IDLE;
        done_nxt  = 1'b1;
      end
      default: phase_nxt = kmc_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= kmc_pkg::SQ_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    if (phase_r == kmc_pkg::SQ_IDLE && start) begin
      ax_r <= dxa[kmc_pkg::MAG_W-1:0];
      ay_r <= dya[kmc_pkg::MAG_W-1:0];
    end
    if (phase_r == kmc_pkg::SQ_X) sq_r <= prod;
    if (phase_r == kmc_pkg::SQ_Y) dist_r <= {1'b0, sq_r} + {1'b0, prod};
  end

  assign done    = done_r;
  assign sq_dist = dist_r;

endmodule

[hdl/kmc_div.sv]
`timescale 1ns / 1ps

module kmc_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [kmc_pkg::SUM_W-1:0]      dividend,
  input  logic        [kmc_pkg::NCNT_W-1:0]     divisor,
  output logic                                  done,
  output logic signed [kmc_pkg::COORD_BITS-1:0] quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [kmc_pkg::DSTEP_W-1:0]   cnt_r;
  logic [kmc_pkg::SUM_W-1:0]     quo_r;
  logic [kmc_pkg::NCNT_W-1:0]    rem_r;
  logic [kmc_pkg::NCNT_W-1:0]    dvs_r;
  logic                          neg_r;
  logic [kmc_pkg::NCNT_W:0]      shifted;
  logic [kmc_pkg::NCNT_W:0]      diff;
  logic                          fits;
  logic [kmc_pkg::SUM_W-1:0]     mag;
  logic [kmc_pkg::COORD_BITS-1:0] q_low;

  assign mag = dividend[kmc_pkg::SUM_W-1] ? -dividend : dividend;

  // one restoring step per cycle on the magnitudes
  always_comb begin
    shifted = {rem_r, quo_r[kmc_pkg::SUM_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == kmc_pkg::DSTEP_W'(kmc_pkg::SUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= mag;
      rem_r <= '0;
      cnt_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[kmc_pkg::SUM_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? diff[kmc_pkg::NCNT_W-1:0] : shifted[kmc_pkg::NCNT_W-1:0];
      quo_r <= {quo_r[kmc_pkg::SUM_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // sign restored, truncation toward zero
  assign q_low    = quo_r[kmc_pkg::COORD_BITS-1:0];
  assign quotient = neg_r ? -q_low : q_low;
  assign done     = done_r;

endmodule

[hdl/kmeans_2d_clustering_top.sv]
`timescale 1ns / 1ps
// channel   | direction | ports                          | content
// in_       | slave     | tvalid tready tdata tuser      | load point, load centroid, run, read
// out_      | master    | tvalid tready tdata tlast      | centroid per cluster, or assignment
// cfg_      | write     | we index wdata                 | cluster, iteration, point counts
//
// load items are taken in the idle state; a read is answered from the read state, which waits out any output stall
// a run's length is set by the shared squarer, which squares x and y for each point/centroid pair,
// and by the bit-serial divider, used for x and y of each cluster per iteration;
// then k centroid beats are emitted; the block takes no item until the run is emitted
// synchronous active-low reset clears control and centroids and sets the configured counts to one

module kmeans_2d_clustering_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [9:0] item_index, [25:10] coord_x, [41:26] coord_y, zero pad
  input  logic [kmc_pkg::IN_DATA_W-1:0]       in_tdata,
  // [1:0] mode
  input  logic [kmc_pkg::MODE_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] cluster_index, [19:4] centroid_x, [35:20] centroid_y, [39:36] assigned_cluster
  output logic [kmc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kmc_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

  localparam int CB = kmc_pkg::COORD_BITS;

  kmc_pkg::state_t state_r, state_nxt;

  // configuration
  logic [kmc_pkg::KCNT_W-1:0] cluster_count_r;
  logic [7:0]                 iteration_count_r;
  logic [kmc_pkg::NCNT_W-1:0] point_count_r;
  logic [kmc_pkg::KCNT_W-1:0] k_eff;
  logic [kmc_pkg::NCNT_W-1:0] n_eff;

  // sequencer counters
  logic [kmc_pkg::PIDX_W-1:0] p_r, p_nxt;
  logic [kmc_pkg::CIDX_W-1:0] c_r, c_nxt;
  logic [7:0]                 it_r, it_nxt;
  logic [kmc_pkg::CIDX_W-1:0] best_r, best_nxt;
  logic [kmc_pkg::DIST_W-1:0] bestd_r, bestd_nxt;
  logic [kmc_pkg::NCNT_W-1:0] hw_r, hw_nxt;

  // stores
  logic signed [CB-1:0] px_mem [kmc_pkg::MAX_POINTS];
  logic signed [CB-1:0] py_mem [kmc_pkg::MAX_POINTS];
  logic [kmc_pkg::CIDX_W-1:0] asg_mem [kmc_pkg::MAX_POINTS];
  logic signed [CB-1:0] px_q_r, py_q_r;
  logic [kmc_pkg::CIDX_W-1:0] asg_q_r;
  logic                 rd_hit_r;
  logic signed [CB-1:0] cx_r [kmc_pkg::MAX_CLUSTERS];
  logic signed [CB-1:0] cy_r [kmc_pkg::MAX_CLUSTERS];
  logic signed [kmc_pkg::SUM_W-1:0] sx_r [kmc_pkg::MAX_CLUSTERS];
  logic signed [kmc_pkg::SUM_W-1:0] sy_r [kmc_pkg::MAX_CLUSTERS];
  logic [kmc_pkg::NCNT_W-1:0]       cnt_r [kmc_pkg::MAX_CLUSTERS];

  // input fields
  logic [kmc_pkg::PIDX_W-1:0] in_idx;
  logic signed [CB-1:0]       in_x, in_y;
  logic                       in_acc;

  // controls
  logic dist_start, dist_done, div_start, div_done;
  logic sum_clr, sum_acc, asg_we, cx_we, cy_we, out_load, slot_free;
  logic [kmc_pkg::DIST_W-1:0]  sq_dist;
  logic signed [CB-1:0]        quotient;
  logic [kmc_pkg::CIDX_W-1:0]  sidx;
  logic signed [kmc_pkg::SUM_W-1:0] div_num;
  logic [kmc_pkg::NCNT_W-1:0]  div_den;
  logic [kmc_pkg::OUT_DATA_W-1:0] out_nxt;
  logic                        last_nxt;

  // output register
  logic                           out_valid_r;
  logic [kmc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                           out_last_r;

  assign in_idx = in_tdata[kmc_pkg::PIDX_W-1:0];
  assign in_x   = in_tdata[kmc_pkg::PIDX_W +: CB];
  assign in_y   = in_tdata[kmc_pkg::PIDX_W + CB +: CB];
  assign in_tready = (state_r == kmc_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // effective counts with out-of-range values clamped
  always_comb begin
    if (cluster_count_r == '0) k_eff = kmc_pkg::KCNT_W'(1);
    else if (cluster_count_r > kmc_pkg::KCNT_W'(kmc_pkg::MAX_CLUSTERS))
      k_eff = kmc_pkg::KCNT_W'(kmc_pkg::MAX_CLUSTERS);
    else k_eff = cluster_count_r;
    if (point_count_r == '0) n_eff = kmc_pkg::NCNT_W'(1);
    else if (point_count_r > kmc_pkg::NCNT_W'(kmc_pkg::MAX_POINTS))
      n_eff = kmc_pkg::NCNT_W'(kmc_pkg::MAX_POINTS);
    else n_eff = point_count_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r   <= kmc_pkg::KCNT_W'(1);
      iteration_count_r <= 8'd1;
      point_count_r     <= kmc_pkg::NCNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        kmc_pkg::REG_CLUSTER_COUNT:   cluster_count_r   <= cfg_wdata[kmc_pkg::KCNT_W-1:0];
        kmc_pkg::REG_ITERATION_COUNT: iteration_count_r <= cfg_wdata[7:0];
        kmc_pkg::REG_POINT_COUNT:     point_count_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // point stores, read at the current point
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == kmc_pkg::MODE_LOAD_POINT) begin
      px_mem[in_idx] <= in_x;
      py_mem[in_idx] <= in_y;
    end
    px_q_r <= px_mem[p_r];
    py_q_r <= py_mem[p_r];
  end

  // assignment store, entries beyond the fill mark read as zero
  always_ff @(posedge clk) begin
    if (asg_we) asg_mem[p_r] <= best_r;
    if (state_r == kmc_pkg::S_IDLE) begin
      asg_q_r  <= asg_mem[in_idx];
      rd_hit_r <= ({1'b0, in_idx} < hw_r);
    end
  end

  // shared arithmetic units
  kmc_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dist_start),
    .px       (px_q_r),
    .py       (py_q_r),
    .cx       (cx_r[c_r]),
    .cy       (cy_r[c_r]),
    .done     (dist_done),
    .sq_dist  (sq_dist)
  );

  assign sidx    = (state_r == kmc_pkg::S_ACC) ? best_r : c_r;
  assign div_num = (state_r == kmc_pkg::S_DYS) ? sy_r[sidx] : sx_r[sidx];
  assign div_den = (cnt_r[sidx] == '0) ? kmc_pkg::NCNT_W'(1) : cnt_r[sidx];

  kmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quotient)
  );

  // centroids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kmc_pkg::MAX_CLUSTERS; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
      end
    end else begin
      if (in_acc && in_tuser == kmc_pkg::MODE_LOAD_CENTROID &&
          in_idx < kmc_pkg::PIDX_W'(kmc_pkg::MAX_CLUSTERS)) begin
        cx_r[in_idx[kmc_pkg::CIDX_W-1:0]] <= in_x;
        cy_r[in_idx[kmc_pkg::CIDX_W-1:0]] <= in_y;
      end
      if (cx_we) cx_r[c_r] <= quotient;
      if (cy_we) cy_r[c_r] <= quotient;
    end
  end

  // per-cluster sums and member counts
  always_ff @(posedge clk) begin
    if (sum_clr) begin
      for (int i = 0; i < kmc_pkg::MAX_CLUSTERS; i++) begin
        sx_r[i]  <= '0;
        sy_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end else if (sum_acc) begin
      sx_r[sidx]  <= sx_r[sidx] + kmc_pkg::SUM_W'(px_q_r);
      sy_r[sidx]  <= sy_r[sidx] + kmc_pkg::SUM_W'(py_q_r);
      cnt_r[sidx] <= cnt_r[sidx] + 1'b1;
    end
  end

  // sequencer state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kmc_pkg::S_IDLE;
      p_r     <= '0;
      c_r     <= '0;
      it_r    <= '0;
      best_r  <= '0;
      bestd_r <= '0;
      hw_r    <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      c_r     <= c_nxt;
      it_r    <= it_nxt;
      best_r  <= best_nxt;
      bestd_r <= bestd_nxt;
      hw_r    <= hw_nxt;
    end
  end

  // next state and controls
  always_comb begin
    state_nxt  = state_r;
    p_nxt      = p_r;
    c_nxt      = c_r;
    it_nxt     = it_r;
    best_nxt   = best_r;
    bestd_nxt  = bestd_r;
    hw_nxt     = hw_r;
    dist_start = 1'b0;
    div_start  = 1'b0;
    sum_clr    = 1'b0;
    sum_acc    = 1'b0;
    asg_we     = 1'b0;
    cx_we      = 1'b0;
    cy_we      = 1'b0;
    out_load   = 1'b0;
    out_nxt    = '0;
    last_nxt   = 1'b0;
    case (state_r)
      kmc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            kmc_pkg::MODE_RUN: begin
              c_nxt = '0;
              if (iteration_count_r == 8'd0) begin
                state_nxt = kmc_pkg::S_EMIT;
              end else begin
                sum_clr   = 1'b1;
                it_nxt    = '0;
                p_nxt     = '0;
                state_nxt = kmc_pkg::S_PFETCH;
              end
            end
            kmc_pkg::MODE_READ: state_nxt = kmc_pkg::S_RD;
            default: ;
          endcase
        end
      end
      kmc_pkg::S_PFETCH: begin
        c_nxt     = '0;
        state_nxt = kmc_pkg::S_DIST;
      end
      kmc_pkg::S_DIST: begin
        dist_start = 1'b1;
        state_nxt  = kmc_pkg::S_DWAIT;
      end
      kmc_pkg::S_DWAIT: begin
        if (dist_done) begin
          if (c_r == '0 || sq_dist < bestd_r) begin
            best_nxt  = c_r;
            bestd_nxt = sq_dist;
          end
          if ({1'b0, c_r} + 1'b1 == k_eff) begin
            state_nxt = kmc_pkg::S_ACC;
          end else begin
            c_nxt     = c_r + 1'b1;
            state_nxt = kmc_pkg::S_DIST;
          end
        end
      end
      kmc_pkg::S_ACC: begin
        asg_we  = 1'b1;
        sum_acc = 1'b1;
        if ({1'b0, p_r} >= hw_r) hw_nxt = {1'b0, p_r} + 1'b1;
        if ({1'b0, p_r} + 1'b1 == n_eff) begin
          c_nxt     = '0;
          state_nxt = kmc_pkg::S_DXS;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = kmc_pkg::S_PFETCH;
        end
      end
      kmc_pkg::S_DXS: begin
        div_start = 1'b1;
        state_nxt = kmc_pkg::S_DXW;
      end
      kmc_pkg::S_DXW: begin
        if (div_done) begin
          cx_we     = 1'b1;
          state_nxt = kmc_pkg::S_DYS;
        end
      end
      kmc_pkg::S_DYS: begin
        div_start = 1'b1;
        state_nxt = kmc_pkg::S_DYW;
      end
      kmc_pkg::S_DYW: begin
        if (div_done) begin
          cy_we = 1'b1;
          if ({1'b0, c_r} + 1'b1 == k_eff) begin
            c_nxt = '0;
            if (it_r + 1'b1 == iteration_count_r) begin
              state_nxt = kmc_pkg::S_EMIT;
            end else begin
              it_nxt    = it_r + 1'b1;
              sum_clr   = 1'b1;
              p_nxt     = '0;
              state_nxt = kmc_pkg::S_PFETCH;
            end
          end else begin
            c_nxt     = c_r + 1'b1;
            state_nxt = kmc_pkg::S_DXS;
          end
        end
      end
      kmc_pkg::S_EMIT: begin
        out_nxt  = {4'd0, cy_r[c_r], cx_r[c_r], c_r};
        last_nxt = ({1'b0, c_r} + 1'b1 == k_eff);
        if (slot_free) begin
          out_load = 1'b1;
          if (last_nxt) state_nxt = kmc_pkg::S_IDLE;
          else c_nxt = c_r + 1'b1;
        end
      end
      kmc_pkg::S_RD: begin
        out_nxt  = {(rd_hit_r ? asg_q_r : 4'd0), 36'd0};
        last_nxt = 1'b1;
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = kmc_pkg::S_IDLE;
        end
      end
      default: state_nxt = kmc_pkg::S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[hdl/kmc_checker.sv]
`timescale 1ns / 1ps

module kmc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [kmc_pkg::MODE_W-1:0]         in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [kmc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic                               out_tlast
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat present after reset");

  // a nonzero assignment only comes from a read, which is always last
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39:36] != 4'd0 |-> out_tlast)
    else $error("assignment result without last");

  // a run keeps the input closed on the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == kmc_pkg::MODE_RUN |=> !in_tready)
    else $error("input open right after a run beat");

endmodule

bind kmeans_2d_clustering_top kmc_checker u_kmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
